### design/two_pkg.sv
// Shared types, constants and helpers for the tracking-wheel odometry step unit.
package two_pkg;

  localparam logic [19:0] PI_Q17      = 20'd411775;
  localparam logic [19:0] TWO_PI_Q17  = 20'd823550;
  localparam logic [19:0] HALF_PI_Q17 = 20'd205887;
  localparam logic [29:0] GAIN_Q30    = 30'd652032874;

  localparam logic [29:0] ATAN_Q30 [32] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
    30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
  };

  typedef enum logic [2:0] {
    CFG_ENABLE     = 3'd0,
    CFG_FWD_OFFSET = 3'd1,
    CFG_SIDE_OFFSET = 3'd2,
    CFG_FWD_TPD    = 3'd3,
    CFG_SIDE_TPD   = 3'd4,
    CFG_TILE_RECIP = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    COR_IDLE, COR_MOD, COR_FOLD, COR_ROT
  } cor_state_e;

  typedef enum logic [4:0] {
    S_IDLE, S_MF, S_MS, S_TR, S_C1, S_DX, S_MX, S_LX, S_DY, S_MY, S_LY,
    S_HSC, S_C2, S_G1, S_G2, S_G3, S_G4, S_G5, S_G6, S_G7, S_FIN
  } seq_state_e;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) return 32'sh7fffffff;
    if (v < -68'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

### design/two_mul.sv
// Shared signed multiplier with a registered product.
module two_mul
  import two_pkg::*;
(
  input  logic                clk_i,
  input  logic signed [33:0]  a_i,
  input  logic signed [32:0]  b_i,
  output logic signed [66:0]  p_o
);

  logic signed [66:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

### design/two_div.sv
// Restoring divider, one quotient bit per cycle, truncating signed result.
module two_div
  import two_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [47:0]  num_i,
  input  logic signed [32:0]  den_i,
  output logic                done_o,
  output logic signed [48:0]  quo_o
);

  logic        busy_q, done_q, neg_q;
  logic [5:0]  cnt_q;
  logic [33:0] rem_q;
  logic [47:0] quo_q;
  logic [32:0] dv_q;
  logic [33:0] rem_sh;

  assign rem_sh = {rem_q[32:0], quo_q[47]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd47) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[47] ^ den_i[32];
      quo_q <= num_i[47] ? 48'(-num_i) : 48'(num_i);
      dv_q  <= den_i[32] ? 33'(-den_i) : 33'(den_i);
      rem_q <= '0;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dv_q}) begin
        rem_q <= rem_sh - {1'b0, dv_q};
        quo_q <= {quo_q[46:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[46:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

### design/two_cordic.sv
// Iterative sine/cosine: range reduction one bit per cycle, then CORDIC rotations.
module two_cordic
  import two_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [34:0]  angle_i,
  output logic                done_o,
  output logic signed [33:0]  sin_o,
  output logic signed [33:0]  cos_o
);

  localparam int CW = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

  cor_state_e state_q, state_d;
  logic [3:0]  mk_q;
  logic [CW-1:0] cnt_q;
  logic        done_q, done_d;
  logic        aneg_q, cneg_q;
  logic [33:0] rem_q;
  logic signed [33:0] x_q, y_q, z_q;
  logic [35:0] sub_k;
  logic signed [23:0] r0, r1, r2;
  logic        fold;
  logic signed [33:0] atan_v, ysh, xsh;

  assign sub_k = {16'd0, TWO_PI_Q17} << mk_q;

  always_comb begin
    r0 = aneg_q ? -$signed({4'd0, rem_q[19:0]}) : $signed({4'd0, rem_q[19:0]});
    r1 = r0;
    if (r0 > $signed({4'd0, PI_Q17})) r1 = r0 - $signed({4'd0, TWO_PI_Q17});
    else if (r0 < -$signed({4'd0, PI_Q17})) r1 = r0 + $signed({4'd0, TWO_PI_Q17});
    fold = 1'b0;
    r2 = r1;
    if (r1 > $signed({4'd0, HALF_PI_Q17})) begin
      r2 = $signed({4'd0, PI_Q17}) - r1;
      fold = 1'b1;
    end else if (r1 < -$signed({4'd0, HALF_PI_Q17})) begin
      r2 = -$signed({4'd0, PI_Q17}) - r1;
      fold = 1'b1;
    end
  end

  assign atan_v = $signed({4'd0, ATAN_Q30[5'(cnt_q)]});
  assign ysh    = y_q >>> cnt_q;
  assign xsh    = x_q >>> cnt_q;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    unique case (state_q)
      COR_IDLE: if (start_i) state_d = COR_MOD;
      COR_MOD:  if (mk_q == 4'd0) state_d = COR_FOLD;
      COR_FOLD: state_d = COR_ROT;
      COR_ROT: begin
        if (cnt_q == CW'(CORDIC_STAGES - 1)) begin
          state_d = COR_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = COR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= COR_IDLE;
      done_q  <= 1'b0;
      mk_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (state_q == COR_IDLE) mk_q <= 4'd15;
      else if (state_q == COR_MOD) mk_q <= mk_q - 4'd1;
      if (state_q == COR_ROT) cnt_q <= cnt_q + CW'(1);
      else cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      COR_IDLE: begin
        if (start_i) begin
          aneg_q <= angle_i[34];
          rem_q  <= angle_i[34] ? 34'(-angle_i) : 34'(angle_i);
        end
      end
      COR_MOD: begin
        // subtract the current shifted 2*pi if it fits
        if ({2'd0, rem_q} >= sub_k) rem_q <= 34'({2'd0, rem_q} - sub_k);
      end
      COR_FOLD: begin
        x_q    <= $signed({4'd0, GAIN_Q30});
        y_q    <= '0;
        z_q    <= 34'(r2) <<< 13;
        cneg_q <= fold;
      end
      COR_ROT: begin
        if (!z_q[33]) begin
          x_q <= x_q - ysh;
          y_q <= y_q + xsh;
          z_q <= z_q - atan_v;
        end else begin
          x_q <= x_q + ysh;
          y_q <= y_q - xsh;
          z_q <= z_q + atan_v;
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign sin_o  = y_q;
  assign cos_o  = cneg_q ? -x_q : x_q;

endmodule

### design/tracking_wheel_odometry_step_unit.sv
// Top level of the tracking-wheel odometry step unit: sequencer, state and ports.
// Each accepted sample runs through one shared multiplier, an iterative CORDIC
// (range reduction, a fold step, CORDIC_STAGES rotations and a done strobe) and a
// one-bit-per-cycle divider with a done strobe. When the heading changed, the CORDIC
// runs twice and the divider twice. With no heading change the divider and the chord
// CORDIC run are skipped. A new sample can be taken in the cycle after the pose is
// loaded into the output register. in_stall_o is high while a sample is in work; a
// finished pose sits in the output register until taken, and a new pose waits in
// the last step while it is full. With odometry disabled, samples are taken and
// dropped.
module tracking_wheel_odometry_step_unit
  import two_pkg::*;
#(
  parameter int POSE_WIDTH    = 32,
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] forward_count_i,
  input  logic signed [31:0] side_count_i,
  input  logic signed [31:0] heading_reading_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pose_x_o,
  output logic signed [31:0] pose_y_o,
  output logic signed [31:0] heading_out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam logic signed [65:0] PMAX = (66'sd1 <<< (POSE_WIDTH - 1)) - 66'sd1;
  localparam logic signed [65:0] PMIN = -PMAX - 66'sd1;

  function automatic logic signed [POSE_WIDTH-1:0] satpw(input logic signed [65:0] v);
    if (v > PMAX) return POSE_WIDTH'(PMAX);
    if (v < PMIN) return POSE_WIDTH'(PMIN);
    return POSE_WIDTH'(v);
  endfunction

  // configuration
  logic               en_q;
  logic signed [15:0] foff_q, soff_q;
  logic [15:0]        ftpd_q, stpd_q, tile_q;

  // state
  logic signed [31:0] lastf_q, lasts_q, head_q;
  logic signed [POSE_WIDTH-1:0] px_q, py_q;

  // work registers
  seq_state_e state_q, state_d;
  logic signed [31:0] fdel_q, sdel_q, ftr_q, str_q, lx_q, ly_q, rad_q;
  logic signed [32:0] d_q;
  logic signed [20:0] chord_q;
  logic signed [33:0] hs_q, hc_q, gx_q, gy_q;
  logic signed [66:0] acc_q;
  logic signed [50:0] tx_q;

  logic               out_valid_q;
  logic signed [31:0] ox_q, oy_q, oh_q;

  logic               accept;
  logic signed [33:0] ma;
  logic signed [32:0] mb;
  logic signed [66:0] mp;
  logic               cor_start, cor_done;
  logic signed [34:0] cor_angle;
  logic signed [33:0] cor_s, cor_c;
  logic               div_start, div_done;
  logic signed [47:0] div_num;
  logic signed [48:0] div_q;
  logic signed [31:0] rad_new, loc_new;
  logic signed [67:0] gsum;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;

  two_mul u_mul (.clk_i, .a_i(ma), .b_i(mb), .p_o(mp));

  two_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk_i, .rst_ni, .start_i(cor_start), .angle_i(cor_angle),
    .done_o(cor_done), .sin_o(cor_s), .cos_o(cor_c)
  );

  two_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(d_q),
    .done_o(div_done), .quo_o(div_q)
  );

  assign cor_angle = (state_q == S_HSC) ? 35'($signed({head_q, 1'b0})) : 35'(d_q);
  assign div_num   = (state_q == S_C1) ? $signed({str_q, 16'd0}) : $signed({ftr_q, 16'd0});
  assign rad_new   = sat32(68'(div_q) + 68'($signed({(state_q == S_DX) ? soff_q : foff_q,
                                                       8'd0})));
  assign loc_new   = sat32(68'(mp >>> 16));
  assign gsum      = (state_q == S_G3) ? 68'(acc_q) + 68'(mp) : 68'(acc_q) - 68'(mp);

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_q)
      S_MF:        begin ma = 34'(fdel_q);  mb = 33'($signed({1'b0, ftpd_q})); end
      S_MS:        begin ma = 34'(sdel_q);  mb = 33'($signed({1'b0, stpd_q})); end
      S_MX, S_MY:  begin ma = 34'(chord_q); mb = 33'(rad_q); end
      S_G1:        begin ma = hc_q; mb = 33'(lx_q); end
      S_G2:        begin ma = hs_q; mb = 33'(ly_q); end
      S_G3:        begin ma = hs_q; mb = 33'(lx_q); end
      S_G4:        begin ma = hc_q; mb = 33'(ly_q); end
      S_G5:        begin ma = gx_q; mb = 33'($signed({1'b0, tile_q})); end
      S_G6:        begin ma = gy_q; mb = 33'($signed({1'b0, tile_q})); end
      default: ;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    cor_start = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      S_IDLE: if (accept && en_q) state_d = S_MF;
      S_MF:   state_d = S_MS;
      S_MS:   state_d = S_TR;
      S_TR: begin
        if (d_q == '0) begin
          state_d = S_HSC;
        end else begin
          cor_start = 1'b1;
          state_d   = S_C1;
        end
      end
      S_C1: begin
        if (cor_done) begin
          div_start = 1'b1;
          state_d   = S_DX;
        end
      end
      S_DX:  if (div_done) state_d = S_MX;
      S_MX:  state_d = S_LX;
      S_LX: begin
        div_start = 1'b1;
        state_d   = S_DY;
      end
      S_DY:  if (div_done) state_d = S_MY;
      S_MY:  state_d = S_LY;
      S_LY:  state_d = S_HSC;
      S_HSC: begin
        cor_start = 1'b1;
        state_d   = S_C2;
      end
      S_C2:  if (cor_done) state_d = S_G1;
      S_G1:  state_d = S_G2;
      S_G2:  state_d = S_G3;
      S_G3:  state_d = S_G4;
      S_G4:  state_d = S_G5;
      S_G5:  state_d = S_G6;
      S_G6:  state_d = S_G7;
      S_G7:  state_d = S_FIN;
      S_FIN: if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      en_q        <= 1'b1;
      foff_q      <= 16'sd1328;
      soff_q      <= '0;
      ftpd_q      <= 16'd1859;
      stpd_q      <= '0;
      tile_q      <= 16'd2731;
      lastf_q     <= '0;
      lasts_q     <= '0;
      head_q      <= '0;
      px_q        <= '0;
      py_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_ENABLE:      en_q   <= cfg_data_i[0];
          CFG_FWD_OFFSET:  foff_q <= $signed(cfg_data_i);
          CFG_SIDE_OFFSET: soff_q <= $signed(cfg_data_i);
          CFG_FWD_TPD:     ftpd_q <= cfg_data_i;
          CFG_SIDE_TPD:    stpd_q <= cfg_data_i;
          CFG_TILE_RECIP:  tile_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept && en_q) begin
        lastf_q <= forward_count_i;
        lasts_q <= side_count_i;
        head_q  <= heading_reading_i;
      end
      if (state_q == S_G7) begin
        px_q <= satpw(66'(px_q) + 66'(tx_q));
        py_q <= satpw(66'(py_q) - 66'(mp >>> 16));
      end
      if (state_q == S_FIN && state_d == S_IDLE) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fdel_q <= forward_count_i - lastf_q;
      sdel_q <= side_count_i - lasts_q;
      d_q    <= 33'(heading_reading_i) - 33'(head_q);
    end
    unique case (state_q)
      S_MS: ftr_q <= sat32(68'(mp));
      S_TR: begin
        str_q <= sat32(68'(mp));
        // straight path when the heading did not move
        if (d_q == '0) begin
          lx_q <= sat32(68'(mp));
          ly_q <= ftr_q;
        end
      end
      S_C1:  if (cor_done) chord_q <= 21'(cor_s >>> 13);
      S_DX:  if (div_done) rad_q <= rad_new;
      S_DY:  if (div_done) rad_q <= rad_new;
      S_LX:  lx_q <= loc_new;
      S_LY:  ly_q <= loc_new;
      S_C2: begin
        if (cor_done) begin
          hs_q <= cor_s;
          hc_q <= cor_c;
        end
      end
      S_G2:  acc_q <= mp;
      S_G3:  gx_q <= 34'(gsum >>> 30);
      S_G4:  acc_q <= mp;
      S_G5:  gy_q <= 34'(gsum >>> 30);
      S_G6:  tx_q <= 51'(mp >>> 16);
      S_FIN: begin
        if (state_d == S_IDLE) begin
          ox_q <= 32'(64'(px_q));
          oy_q <= 32'(64'(py_q));
          oh_q <= head_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign pose_x_o      = ox_q;
  assign pose_y_o      = oy_q;
  assign heading_out_o = oh_q;

endmodule
